[rtl/svm_pkg.sv]
`timescale 1ns / 1ps

package svm_pkg;

  // Voice count and per-voice clip depth. The clip depth must be a power of two
  // so that a clip memory address is the voice index placed above the word address.
  localparam int NumVoices  = 3;
  localparam int ClipDepth  = 16384;
  localparam int NumLenRegs = 3;

  localparam int ClipAw    = $clog2(ClipDepth);
  localparam int VoiceIdxW = (NumVoices > 1) ? $clog2(NumVoices) : 1;
  localparam int MemDepth  = NumVoices * ClipDepth;
  localparam int MemAw     = $clog2(MemDepth);

  localparam int SampleW = 16;
  localparam int LenW    = 15;
  localparam int CfgIdxW = 2;
  localparam int CfgW    = 15;

  localparam logic [LenW-1:0] ClipDepthLen = LenW'(ClipDepth);

  // Operation codes carried in the func field.
  localparam logic [1:0] FuncLoad = 2'd0;
  localparam logic [1:0] FuncCmd  = 2'd1;
  localparam logic [1:0] FuncMix  = 2'd2;

  typedef enum logic [1:0] {
    MODE_OFF  = 2'd0,
    MODE_ONCE = 2'd1,
    MODE_LOOP = 2'd2
  } mode_e;

  typedef enum logic [1:0] {
    ST_IDLE   = 2'd0,
    ST_VOICE  = 2'd1,
    ST_FINISH = 2'd2
  } state_e;

  typedef struct packed {
    logic [1:0]                func;
    logic [1:0]                voice;
    logic [13:0]               clip_address;
    logic signed [SampleW-1:0] clip_word;
    logic [1:0]                mode_req;
    logic signed [SampleW-1:0] left_in;
    logic signed [SampleW-1:0] right_in;
  } in_item_t;

  typedef struct packed {
    logic signed [SampleW-1:0] left_out;
    logic signed [SampleW-1:0] right_out;
  } out_item_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic                 accept;
    logic                 start_mix;
    logic                 voice_en;
    logic [VoiceIdxW-1:0] voice_idx;
    logic                 load_out;
  } svm_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_free;
  } svm_status_t;

endpackage

[rtl/svm_ram.sv]
`timescale 1ns / 1ps

module svm_ram #(
  parameter int Width = 16,
  parameter int Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/svm_ctrl.sv]
`timescale 1ns / 1ps

module svm_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  input  logic [1:0]             in_func_i,
  output logic                   in_stall_o,
  input  svm_pkg::svm_status_t   status_i,
  output svm_pkg::svm_cmd_t      cmd_o
);

  svm_pkg::state_e                   state_q, state_d;
  logic [svm_pkg::VoiceIdxW-1:0]     vcnt_q, vcnt_d;
  logic                              accept;

  assign in_stall_o = (state_q != svm_pkg::ST_IDLE);
  assign accept     = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= svm_pkg::ST_IDLE;
      vcnt_q  <= '0;
    end else begin
      state_q <= state_d;
      vcnt_q  <= vcnt_d;
    end
  end

  always_comb begin
    state_d       = state_q;
    vcnt_d        = vcnt_q;
    cmd_o         = '0;
    cmd_o.accept  = accept;
    cmd_o.voice_idx = vcnt_q;
    case (state_q)
      svm_pkg::ST_IDLE: begin
        if (accept && in_func_i == svm_pkg::FuncMix) begin
          cmd_o.start_mix = 1'b1;
          vcnt_d          = '0;
          state_d         = svm_pkg::ST_VOICE;
        end
      end
      svm_pkg::ST_VOICE: begin
        cmd_o.voice_en = 1'b1;
        if (vcnt_q == svm_pkg::VoiceIdxW'(svm_pkg::NumVoices - 1)) begin
          state_d = svm_pkg::ST_FINISH;
        end else begin
          vcnt_d = vcnt_q + 1'b1;
        end
      end
      svm_pkg::ST_FINISH: begin
        if (status_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = svm_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = svm_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

[rtl/svm_dp.sv]
`timescale 1ns / 1ps

module svm_dp (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  svm_pkg::in_item_t            in_data_i,
  input  logic                         cfg_we_i,
  input  logic [svm_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [svm_pkg::CfgW-1:0]     cfg_data_i,
  input  svm_pkg::svm_cmd_t            cmd_i,
  output svm_pkg::svm_status_t         status_o,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output svm_pkg::out_item_t           out_data_o
);

  localparam int NV = svm_pkg::NumVoices;

  logic [svm_pkg::LenW-1:0]    len_q   [NV];
  logic [svm_pkg::LenW-1:0]    len_d   [NV];
  logic [svm_pkg::LenW-1:0]    len_eff [NV];
  logic [svm_pkg::LenW-1:0]    pos_q   [NV];
  logic [svm_pkg::LenW-1:0]    pos_d   [NV];
  svm_pkg::mode_e              mode_q  [NV];
  svm_pkg::mode_e              mode_d  [NV];

  logic signed [svm_pkg::SampleW-1:0] acc_l_q, acc_l_d, acc_r_q, acc_r_d;
  logic signed [svm_pkg::SampleW-1:0] sum_l, sum_r;
  logic                               rd_pend_q, rd_pend_d;
  svm_pkg::out_item_t                 out_q;
  logic                               out_valid_q, out_valid_d;

  logic                              ram_we, ram_re;
  logic [svm_pkg::MemAw-1:0]         ram_waddr, ram_raddr;
  logic [svm_pkg::SampleW-1:0]       ram_rdata;

  logic                              voice_ok;
  logic [svm_pkg::LenW-1:0]          eff_pos;
  svm_pkg::mode_e                    vmode;
  logic [svm_pkg::LenW-1:0]          vlen;

  always_comb begin
    for (int i = 0; i < NV; i++) begin
      len_eff[i] = (len_q[i] > svm_pkg::ClipDepthLen) ? svm_pkg::ClipDepthLen : len_q[i];
    end
  end

  assign voice_ok = (32'(in_data_i.voice) < NV) &&
                    (32'(in_data_i.clip_address) < svm_pkg::ClipDepth);

  // Clip memory load port.
  assign ram_we    = cmd_i.accept && (in_data_i.func == svm_pkg::FuncLoad) && voice_ok;
  assign ram_waddr = svm_pkg::MemAw'({in_data_i.voice,
                                      in_data_i.clip_address[svm_pkg::ClipAw-1:0]});

  assign vmode = mode_q[cmd_i.voice_idx];
  assign vlen  = len_eff[cmd_i.voice_idx];

  // Accumulate the word read for the previous voice, if any.
  assign sum_l = rd_pend_q ? acc_l_q + $signed(ram_rdata) : acc_l_q;
  assign sum_r = rd_pend_q ? acc_r_q + $signed(ram_rdata) : acc_r_q;

  always_comb begin
    len_d       = len_q;
    pos_d       = pos_q;
    mode_d      = mode_q;
    acc_l_d     = sum_l;
    acc_r_d     = sum_r;
    rd_pend_d   = 1'b0;
    ram_re      = 1'b0;
    eff_pos     = pos_q[cmd_i.voice_idx];
    out_valid_d = out_valid_q && out_stall_i;

    for (int i = 0; i < svm_pkg::NumLenRegs; i++) begin
      if (cfg_we_i && 32'(cfg_index_i) == i && i < NV) begin
        len_d[i] = cfg_data_i;
      end
    end

    if (cmd_i.accept && in_data_i.func == svm_pkg::FuncCmd &&
        32'(in_data_i.voice) < NV &&
        in_data_i.mode_req <= svm_pkg::MODE_LOOP &&
        len_eff[in_data_i.voice] != '0) begin
      mode_d[in_data_i.voice] = svm_pkg::mode_e'(in_data_i.mode_req);
      if (in_data_i.mode_req == svm_pkg::MODE_OFF) begin
        pos_d[in_data_i.voice] = '0;
      end
    end

    if (cmd_i.start_mix) begin
      acc_l_d = in_data_i.left_in;
      acc_r_d = in_data_i.right_in;
    end

    if (cmd_i.voice_en && vmode != svm_pkg::MODE_OFF) begin
      if (pos_q[cmd_i.voice_idx] >= vlen &&
          (vmode == svm_pkg::MODE_ONCE || vlen == '0)) begin
        // End of a one-shot clip, or a clip whose length was cleared.
        mode_d[cmd_i.voice_idx] = svm_pkg::MODE_OFF;
        pos_d[cmd_i.voice_idx]  = '0;
      end else begin
        if (pos_q[cmd_i.voice_idx] >= vlen) begin
          eff_pos = '0;
        end
        ram_re                 = 1'b1;
        rd_pend_d              = 1'b1;
        pos_d[cmd_i.voice_idx] = eff_pos + 1'b1;
      end
    end

    if (cmd_i.load_out) begin
      out_valid_d = 1'b1;
    end
  end

  assign ram_raddr = svm_pkg::MemAw'({cmd_i.voice_idx, eff_pos[svm_pkg::ClipAw-1:0]});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NV; i++) begin
        len_q[i]  <= '0;
        pos_q[i]  <= '0;
        mode_q[i] <= svm_pkg::MODE_OFF;
      end
      rd_pend_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      len_q       <= len_d;
      pos_q       <= pos_d;
      mode_q      <= mode_d;
      rd_pend_q   <= rd_pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_l_q <= acc_l_d;
    acc_r_q <= acc_r_d;
    if (cmd_i.load_out) begin
      out_q.left_out  <= sum_l;
      out_q.right_out <= sum_r;
    end
  end

  assign status_o.out_free = !out_valid_q || !out_stall_i;
  assign out_valid_o       = out_valid_q;
  assign out_data_o        = out_q;

  svm_ram #(
    .Width (svm_pkg::SampleW),
    .Depth (svm_pkg::MemDepth)
  ) u_clip_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (in_data_i.clip_word),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

endmodule

[rtl/sample_playback_voice_mixer.sv]
`timescale 1ns / 1ps

// Sample playback voice mixer. Three voices play signed 16-bit mono clips held in
// a single clip memory of three 16384-word regions, one per voice, and add them
// into a stereo frame. A load beat writes one clip word and a command beat sets a
// voice to off, play once or loop; while no mix is in progress they may follow
// one another in consecutive cycles. A mix beat passes through acceptance, a
// voice step for each voice in turn, in which that voice's word is read from the
// single read port of the clip memory if the voice is playing, and a final step
// in which the last word is added and the frame is written to the output register.
// The input is stalled while a mix is in progress, and the finished frame waits
// in the output register so that the next beat can be taken while it is pending.
// A mix that finds the output register still holding a stalled frame waits in its
// final step until that frame is taken. Clip memory is not cleared at reset, so a
// voice must only be played over words that have been loaded. Clip length
// registers above 16384 act as 16384; the user must write them through the plain
// configuration port only while the block is idle, which it does not enforce.

module sample_playback_voice_mixer (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  svm_pkg::in_item_t            in_data_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output svm_pkg::out_item_t           out_data_o,
  input  logic                         cfg_we_i,
  input  logic [svm_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [svm_pkg::CfgW-1:0]     cfg_data_i
);

  // The controller sequences a mix over the voices; the datapath holds the
  // voice state, the length registers, the accumulators and the clip memory.
  svm_pkg::svm_cmd_t    cmd;
  svm_pkg::svm_status_t status;

  svm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_func_i  (in_data_i.func),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  svm_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule
